// File: rtl/core/ddnms_pkg.sv
package ddnms_pkg;

  // Field widths fixed by the port list
  localparam int COORD_W = 29;
  localparam int SCORE_W = 31;
  localparam int ELEM_W  = 32;
  localparam int AREA_W  = 2 * COORD_W;

  // Input word kinds
  typedef enum logic {
    CMD_ELEMENT = 1'b0,
    CMD_FETCH   = 1'b1
  } ddnms_command_e;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_CLASS_COUNT = 2'd0;
  localparam logic [1:0] REG_NET_WIDTH   = 2'd1;
  localparam logic [1:0] REG_NET_HEIGHT  = 2'd2;
  localparam logic [1:0] REG_SCORE_THR   = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic elem;
    logic fetch_kept;
    logic fetch_cand;
    logic fetch_out;
    logic sel_start;
    logic scan_start;
    logic scan_step;
    logic load_c_rd;
    logic load_c;
    logic area_c;
    logic k_rd;
    logic e_rd;
    logic geom;
    logic mul;
    logic decide;
    logic commit;
  } ddnms_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pipe_busy;
    logic scan_done;
    logic cmp_more;
    logic pass_more;
    logic out_free;
  } ddnms_stat_t;

endpackage

// File: rtl/core/detection_decode_with_nms.sv
// Channel   Direction  Handshake               Word
// input     in         in_valid_i/in_stall_o   command_i, element_value_i, last_of_frame_i
// output    out        out_valid_o/out_stall_i valid_res_o .. overflow_o
// config    in         psel/penable/pwrite     paddr, pwdata, prdata (APB, pready tied high)
//
// A tensor word stalls intake only if it ends the frame; a finished anchor leaves
// a two-stage corner pipe. A fetch holds intake through accept, kept list read,
// candidate store read and output load (held while the previous output word waits).
// After the last word of a frame, the corner pipe drains; each pick then scans the
// store, loads and sizes the candidate as setup, checks it against each kept box
// (until a drop) and commits; intake stalls until it ends.
// Reset clears the registers but not the stores; the stores need no clearing pass.
module detection_decode_with_nms
  import ddnms_pkg::*;
#(
  parameter int CAND_MAX  = 1024,
  parameter int MAX_KEPT  = 300,
  parameter int CLASS_MAX = 128
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [3:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     command_i,
  input  logic signed [ELEM_W-1:0] element_value_i,
  input  logic                     last_of_frame_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     valid_res_o,
  output logic [6:0]               label_o,
  output logic [COORD_W-1:0]       left_o,
  output logic [COORD_W-1:0]       top_o,
  output logic [COORD_W-1:0]       box_w_o,
  output logic [COORD_W-1:0]       box_h_o,
  output logic [SCORE_W-1:0]       confidence_o,
  output logic                     last_detection_o,
  output logic                     overflow_o
);

  logic [7:0]         class_count_q;
  logic [12:0]        net_width_q, net_height_q;
  logic [SCORE_W-1:0] score_thr_q;
  logic               cfg_wr;
  ddnms_cmd_t         cmd;
  ddnms_stat_t        stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_count_q <= 8'd80;
      net_width_q   <= 13'd640;
      net_height_q  <= 13'd640;
      score_thr_q   <= 31'd16384;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_CLASS_COUNT: class_count_q <= pwdata[7:0];
        REG_NET_WIDTH:   net_width_q   <= pwdata[12:0];
        REG_NET_HEIGHT:  net_height_q  <= pwdata[12:0];
        REG_SCORE_THR:   score_thr_q   <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[3:2])
      REG_CLASS_COUNT: prdata = 32'(class_count_q);
      REG_NET_WIDTH:   prdata = 32'(net_width_q);
      REG_NET_HEIGHT:  prdata = 32'(net_height_q);
      REG_SCORE_THR:   prdata = 32'(score_thr_q);
      default:         prdata = '0;
    endcase
  end

  ddnms_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .command_i       (command_i),
    .last_of_frame_i (last_of_frame_i),
    .stat_i          (stat),
    .in_stall_o      (in_stall_o),
    .cmd_o           (cmd)
  );

  ddnms_dp #(
    .CAND_MAX  (CAND_MAX),
    .MAX_KEPT  (MAX_KEPT),
    .CLASS_MAX (CLASS_MAX)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .class_count_i     (class_count_q),
    .net_width_i       (net_width_q),
    .net_height_i      (net_height_q),
    .score_threshold_i (score_thr_q),
    .element_value_i   (element_value_i),
    .last_of_frame_i   (last_of_frame_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .valid_res_o       (valid_res_o),
    .label_o           (label_o),
    .left_o            (left_o),
    .top_o             (top_o),
    .box_w_o           (box_w_o),
    .box_h_o           (box_h_o),
    .confidence_o      (confidence_o),
    .last_detection_o  (last_detection_o),
    .overflow_o        (overflow_o)
  );

endmodule

// File: rtl/core/ddnms_ram.sv
module ddnms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/ddnms_ctrl.sv
module ddnms_ctrl
  import ddnms_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        command_i,
  input  logic        last_of_frame_i,
  input  ddnms_stat_t stat_i,
  output logic        in_stall_o,
  output ddnms_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DRAIN,
    S_PASS,
    S_SCAN,
    S_CRD,
    S_CLD,
    S_CAREA,
    S_CHECK,
    S_KRD,
    S_ERD,
    S_GEOM,
    S_MUL,
    S_DEC,
    S_FKEPT,
    S_FCAND,
    S_FOUT
  } state_e;

  state_e state_q, state_d;
  logic   take;

  assign take       = (state_q == S_IDLE) && in_valid_i;
  assign in_stall_o = (state_q != S_IDLE);

  // Decode commands and next state
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (take) begin
          if (command_i == CMD_FETCH) begin
            state_d = S_FKEPT;
          end else begin
            cmd_o.elem = 1'b1;
            if (last_of_frame_i) state_d = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          cmd_o.sel_start = 1'b1;
          state_d = S_PASS;
        end
      end
      S_PASS: begin
        if (stat_i.pass_more) begin
          cmd_o.scan_start = 1'b1;
          state_d = S_SCAN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_done) state_d = S_CRD;
      end
      S_CRD: begin
        cmd_o.load_c_rd = 1'b1;
        state_d = S_CLD;
      end
      S_CLD: begin
        cmd_o.load_c = 1'b1;
        state_d = S_CAREA;
      end
      S_CAREA: begin
        cmd_o.area_c = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (stat_i.cmp_more) begin
          state_d = S_KRD;
        end else begin
          cmd_o.commit = 1'b1;
          state_d = S_PASS;
        end
      end
      S_KRD: begin
        cmd_o.k_rd = 1'b1;
        state_d = S_ERD;
      end
      S_ERD: begin
        cmd_o.e_rd = 1'b1;
        state_d = S_GEOM;
      end
      S_GEOM: begin
        cmd_o.geom = 1'b1;
        state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_DEC;
      end
      S_DEC: begin
        cmd_o.decide = 1'b1;
        state_d = S_CHECK;
      end
      S_FKEPT: begin
        cmd_o.fetch_kept = 1'b1;
        state_d = S_FCAND;
      end
      S_FCAND: begin
        cmd_o.fetch_cand = 1'b1;
        state_d = S_FOUT;
      end
      S_FOUT: begin
        if (stat_i.out_free) begin
          cmd_o.fetch_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/core/ddnms_dp.sv
module ddnms_dp
  import ddnms_pkg::*;
#(
  parameter int CAND_MAX  = 1024,
  parameter int MAX_KEPT  = 300,
  parameter int CLASS_MAX = 128
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ddnms_cmd_t               cmd_i,
  output ddnms_stat_t              stat_o,
  input  logic [7:0]               class_count_i,
  input  logic [12:0]              net_width_i,
  input  logic [12:0]              net_height_i,
  input  logic [SCORE_W-1:0]       score_threshold_i,
  input  logic signed [ELEM_W-1:0] element_value_i,
  input  logic                     last_of_frame_i,
  input  logic                     out_stall_i,
  output logic                     out_valid_o,
  output logic                     valid_res_o,
  output logic [6:0]               label_o,
  output logic [COORD_W-1:0]       left_o,
  output logic [COORD_W-1:0]       top_o,
  output logic [COORD_W-1:0]       box_w_o,
  output logic [COORD_W-1:0]       box_h_o,
  output logic [SCORE_W-1:0]       confidence_o,
  output logic                     last_detection_o,
  output logic                     overflow_o
);

  localparam int CIW    = $clog2(CAND_MAX);
  localparam int CCW    = $clog2(CAND_MAX + 1);
  localparam int KIW    = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int KCW    = $clog2(MAX_KEPT + 1);
  localparam int NC_MAX = (CLASS_MAX < 255) ? CLASS_MAX : 255;
  localparam int EIW    = $clog2(NC_MAX + 5);
  localparam int CLW    = (NC_MAX > 1) ? $clog2(NC_MAX) : 1;
  localparam int SCW    = SCORE_W + CLW;
  localparam int XYW    = 2 * COORD_W;
  localparam int SUMW   = ELEM_W + 2;
  localparam int UNIW   = AREA_W + 1;

  // Clamp a corner to [0, hi]
  function automatic logic [COORD_W-1:0] clamp_to(input logic signed [SUMW-1:0] v,
                                                  input logic [COORD_W-1:0] hi);
    logic signed [SUMW-1:0] lim;
    lim = $signed({{(SUMW-COORD_W){1'b0}}, hi});
    if (v < 0) return '0;
    if (v > lim) return hi;
    return v[COORD_W-1:0];
  endfunction

  // ---------------- anchor accumulation ----------------
  logic [EIW-1:0]           ei_q, ei_eff, ei_nxt, nc, ncp4;
  logic signed [ELEM_W-1:0] box_q [4];
  logic signed [ELEM_W-1:0] best_q, best_n;
  logic [CLW-1:0]           cls_q, cls_n;
  logic                     fin;

  // Stage A: finished anchor snapshot
  logic                     a_v_q, a_pass_q;
  logic signed [ELEM_W-1:0] a_cx_q, a_cy_q, a_w_q, a_h_q;
  logic [SCORE_W-1:0]       a_score_q;
  logic [CLW-1:0]           a_cls_q;

  // Stage B: raw corners
  logic                     b_v_q, b_pass_q;
  logic signed [SUMW-1:0]   b_x1_q, b_x2_q, b_y1_q, b_y2_q;
  logic [SCORE_W-1:0]       b_score_q;
  logic [CLW-1:0]           b_cls_q;
  logic signed [SUMW-1:0]   a_hw, a_hh;
  logic [COORD_W-1:0]       wl, hl, x1c, x2c, y1c, y2c;
  logic                     b_keep, b_write;

  // Candidate store state
  logic [CCW-1:0] cnt_q;
  logic           ovf_q, closed_q;

  // Selection and suppression
  logic [CCW-1:0]     picks_q, j_q;
  logic               have_prev_q, rdv_q, found_q, scan_rd, elig;
  logic [SCORE_W-1:0] prev_s_q, bs_q, sc_s;
  logic [CIW-1:0]     prev_i_q, ridx_q, bi_q;
  logic [CLW-1:0]     bcls_q, sc_cl;
  logic [COORD_W-1:0] c_x1_q, c_x2_q, c_y1_q, c_y2_q;
  logic [COORD_W-1:0] e_x1, e_x2, e_y1, e_y2, lx, rx, ty, by;
  logic [AREA_W-1:0]  aa_q, inter_q, ab_q;
  logic [COORD_W-1:0] iw_q, ih_q, we_q, he_q;
  logic               ceq_q, drop_q, hit_q, ovl;
  logic [UNIW-1:0]    uni;
  logic [KCW-1:0]     k_q, kc_q, fp_q;

  // Memories
  logic           cand_re;
  logic [CIW-1:0] cand_raddr, cand_waddr, kept_rdata;
  logic [XYW-1:0] xpair_rd, ypair_rd;
  logic [SCW-1:0] sc_rd;
  logic           kept_re, kept_we;
  logic [KIW-1:0] kept_raddr;

  // Output word
  logic out_v_q, out_free;

  // Effective class count and element position
  always_comb begin
    if (class_count_i == 8'd0) begin
      nc = EIW'(1);
    end else if ({1'b0, class_count_i} > 9'(NC_MAX)) begin
      nc = EIW'(NC_MAX);
    end else begin
      nc = EIW'(class_count_i);
    end
    ncp4   = nc + EIW'(4);
    ei_eff = (ei_q >= ncp4) ? '0 : ei_q;
    ei_nxt = ei_eff + EIW'(1);
    fin    = (ei_nxt >= ncp4);
    best_n = best_q;
    cls_n  = cls_q;
    if (ei_eff < EIW'(4)) begin
      if (ei_eff == '0) begin
        best_n = '0;
        cls_n  = '0;
      end
    end else if (element_value_i > best_q) begin
      best_n = element_value_i;
      cls_n  = CLW'(ei_eff - EIW'(4));
    end
  end

  // Corner clamp and emptiness test
  assign a_hw    = SUMW'(a_w_q >>> 1);
  assign a_hh    = SUMW'(a_h_q >>> 1);
  assign wl      = {net_width_i, 16'd0};
  assign hl      = {net_height_i, 16'd0};
  assign x1c     = clamp_to(b_x1_q, wl);
  assign x2c     = clamp_to(b_x2_q, wl);
  assign y1c     = clamp_to(b_y1_q, hl);
  assign y2c     = clamp_to(b_y2_q, hl);
  assign b_keep  = b_v_q && b_pass_q && (x2c > x1c) && (y2c > y1c);
  assign b_write = b_keep && (cnt_q < CCW'(CAND_MAX));
  assign cand_waddr = cnt_q[CIW-1:0];

  // Scan candidate fields
  assign scan_rd = cmd_i.scan_step && (j_q < cnt_q);
  assign sc_s    = sc_rd[SCW-1:CLW];
  assign sc_cl   = sc_rd[CLW-1:0];
  assign elig    = !have_prev_q || (sc_s < prev_s_q) ||
                   ((sc_s == prev_s_q) && (ridx_q > prev_i_q));

  // Overlap geometry against a kept box
  assign e_x1 = xpair_rd[XYW-1:COORD_W];
  assign e_x2 = xpair_rd[COORD_W-1:0];
  assign e_y1 = ypair_rd[XYW-1:COORD_W];
  assign e_y2 = ypair_rd[COORD_W-1:0];
  assign lx   = (c_x1_q > e_x1) ? c_x1_q : e_x1;
  assign rx   = (c_x2_q < e_x2) ? c_x2_q : e_x2;
  assign ty   = (c_y1_q > e_y1) ? c_y1_q : e_y1;
  assign by   = (c_y2_q < e_y2) ? c_y2_q : e_y2;
  assign uni  = UNIW'(aa_q) + UNIW'(ab_q) - UNIW'(inter_q);
  assign ovl  = ceq_q && (uni != '0) && ({inter_q, 1'b0} > uni);

  // Memory ports
  assign cand_re    = scan_rd || cmd_i.load_c_rd || cmd_i.e_rd || cmd_i.fetch_cand;
  assign cand_raddr = scan_rd ? j_q[CIW-1:0] : (cmd_i.load_c_rd ? bi_q : kept_rdata);
  assign kept_re    = cmd_i.k_rd || cmd_i.fetch_kept;
  assign kept_raddr = cmd_i.k_rd ? k_q[KIW-1:0] : fp_q[KIW-1:0];
  assign kept_we    = cmd_i.commit && !drop_q;

  ddnms_ram #(.WIDTH(XYW), .DEPTH(CAND_MAX)) u_xpair (
    .clk_i   (clk_i),
    .we_i    (b_write),
    .waddr_i (cand_waddr),
    .wdata_i ({x1c, x2c}),
    .re_i    (cand_re),
    .raddr_i (cand_raddr),
    .rdata_o (xpair_rd)
  );

  ddnms_ram #(.WIDTH(XYW), .DEPTH(CAND_MAX)) u_ypair (
    .clk_i   (clk_i),
    .we_i    (b_write),
    .waddr_i (cand_waddr),
    .wdata_i ({y1c, y2c}),
    .re_i    (cand_re),
    .raddr_i (cand_raddr),
    .rdata_o (ypair_rd)
  );

  ddnms_ram #(.WIDTH(SCW), .DEPTH(CAND_MAX)) u_score (
    .clk_i   (clk_i),
    .we_i    (b_write),
    .waddr_i (cand_waddr),
    .wdata_i ({b_score_q, b_cls_q}),
    .re_i    (cand_re),
    .raddr_i (cand_raddr),
    .rdata_o (sc_rd)
  );

  ddnms_ram #(.WIDTH(CIW), .DEPTH(MAX_KEPT)) u_kept (
    .clk_i   (clk_i),
    .we_i    (kept_we),
    .waddr_i (kc_q[KIW-1:0]),
    .wdata_i (bi_q),
    .re_i    (kept_re),
    .raddr_i (kept_raddr),
    .rdata_o (kept_rdata)
  );

  assign out_free = !out_v_q || !out_stall_i;

  // Status
  assign stat_o.pipe_busy = a_v_q || b_v_q;
  assign stat_o.scan_done = (j_q >= cnt_q) && !rdv_q;
  assign stat_o.cmp_more  = (k_q < kc_q) && !drop_q;
  assign stat_o.pass_more = (picks_q < cnt_q) && (kc_q < KCW'(MAX_KEPT));
  assign stat_o.out_free  = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ei_q        <= '0;
      for (int i = 0; i < 4; i++) box_q[i] <= '0;
      best_q      <= '0;
      cls_q       <= '0;
      a_v_q       <= 1'b0;
      a_pass_q    <= 1'b0;
      a_cx_q      <= '0;
      a_cy_q      <= '0;
      a_w_q       <= '0;
      a_h_q       <= '0;
      a_score_q   <= '0;
      a_cls_q     <= '0;
      b_v_q       <= 1'b0;
      b_pass_q    <= 1'b0;
      b_x1_q      <= '0;
      b_x2_q      <= '0;
      b_y1_q      <= '0;
      b_y2_q      <= '0;
      b_score_q   <= '0;
      b_cls_q     <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      closed_q    <= 1'b0;
      picks_q     <= '0;
      j_q         <= '0;
      have_prev_q <= 1'b0;
      rdv_q       <= 1'b0;
      found_q     <= 1'b0;
      prev_s_q    <= '0;
      prev_i_q    <= '0;
      bs_q        <= '0;
      bi_q        <= '0;
      bcls_q      <= '0;
      ridx_q      <= '0;
      c_x1_q      <= '0;
      c_x2_q      <= '0;
      c_y1_q      <= '0;
      c_y2_q      <= '0;
      aa_q        <= '0;
      iw_q        <= '0;
      ih_q        <= '0;
      we_q        <= '0;
      he_q        <= '0;
      ceq_q       <= 1'b0;
      inter_q     <= '0;
      ab_q        <= '0;
      drop_q      <= 1'b0;
      k_q         <= '0;
      kc_q        <= '0;
      fp_q        <= '0;
      hit_q       <= 1'b0;
      out_v_q          <= 1'b0;
      valid_res_o      <= 1'b0;
      label_o          <= '0;
      left_o           <= '0;
      top_o            <= '0;
      box_w_o          <= '0;
      box_h_o          <= '0;
      confidence_o     <= '0;
      last_detection_o <= 1'b0;
      overflow_o       <= 1'b0;
    end else begin
      // Accumulate one tensor word
      a_v_q <= 1'b0;
      if (cmd_i.elem) begin
        if (closed_q) begin
          closed_q <= 1'b0;
          cnt_q    <= '0;
          kc_q     <= '0;
          fp_q     <= '0;
          ovf_q    <= 1'b0;
        end
        if (ei_eff < EIW'(4)) box_q[ei_eff[1:0]] <= element_value_i;
        best_q <= best_n;
        cls_q  <= cls_n;
        ei_q   <= (fin || last_of_frame_i) ? '0 : ei_nxt;
        if (fin) begin
          a_v_q     <= 1'b1;
          a_pass_q  <= (best_n >= $signed({1'b0, score_threshold_i}));
          a_cx_q    <= box_q[0];
          a_cy_q    <= box_q[1];
          a_w_q     <= box_q[2];
          a_h_q     <= box_q[3];
          a_score_q <= best_n[SCORE_W-1:0];
          a_cls_q   <= cls_n;
        end
      end

      // Form raw corners
      b_v_q     <= a_v_q;
      b_pass_q  <= a_pass_q;
      b_x1_q    <= SUMW'(a_cx_q) - a_hw;
      b_x2_q    <= SUMW'(a_cx_q) + a_hw;
      b_y1_q    <= SUMW'(a_cy_q) - a_hh;
      b_y2_q    <= SUMW'(a_cy_q) + a_hh;
      b_score_q <= a_score_q;
      b_cls_q   <= a_cls_q;

      // Store a survivor or flag the drop
      if (b_keep) begin
        if (b_write) cnt_q <= cnt_q + CCW'(1);
        else ovf_q <= 1'b1;
      end

      // Frame close
      if (cmd_i.sel_start) begin
        picks_q     <= '0;
        have_prev_q <= 1'b0;
        kc_q        <= '0;
        fp_q        <= '0;
        closed_q    <= 1'b1;
      end
      if (cmd_i.scan_start) begin
        j_q     <= '0;
        rdv_q   <= 1'b0;
        found_q <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        rdv_q <= scan_rd;
        if (scan_rd) begin
          ridx_q <= j_q[CIW-1:0];
          j_q    <= j_q + CCW'(1);
        end
        if (rdv_q && elig && (!found_q || (sc_s > bs_q))) begin
          found_q <= 1'b1;
          bs_q    <= sc_s;
          bi_q    <= ridx_q;
          bcls_q  <= sc_cl;
        end
      end
      if (cmd_i.load_c) begin
        c_x1_q <= e_x1;
        c_x2_q <= e_x2;
        c_y1_q <= e_y1;
        c_y2_q <= e_y2;
      end
      if (cmd_i.area_c) begin
        aa_q   <= AREA_W'(c_x2_q - c_x1_q) * AREA_W'(c_y2_q - c_y1_q);
        k_q    <= '0;
        drop_q <= 1'b0;
      end
      if (cmd_i.geom) begin
        iw_q  <= (rx > lx) ? rx - lx : '0;
        ih_q  <= (by > ty) ? by - ty : '0;
        we_q  <= e_x2 - e_x1;
        he_q  <= e_y2 - e_y1;
        ceq_q <= (sc_cl == bcls_q);
      end
      if (cmd_i.mul) begin
        inter_q <= AREA_W'(iw_q) * AREA_W'(ih_q);
        ab_q    <= AREA_W'(we_q) * AREA_W'(he_q);
      end
      if (cmd_i.decide) begin
        drop_q <= drop_q || ovl;
        k_q    <= k_q + KCW'(1);
      end
      if (cmd_i.commit) begin
        if (!drop_q) kc_q <= kc_q + KCW'(1);
        prev_s_q    <= bs_q;
        prev_i_q    <= bi_q;
        have_prev_q <= 1'b1;
        picks_q     <= picks_q + CCW'(1);
      end

      // Fetch a kept detection
      if (cmd_i.fetch_kept) hit_q <= (fp_q < kc_q);
      if (cmd_i.fetch_out) begin
        out_v_q     <= 1'b1;
        overflow_o  <= ovf_q;
        valid_res_o <= hit_q;
        if (hit_q) begin
          label_o          <= 7'(sc_cl);
          left_o           <= e_x1;
          top_o            <= e_y1;
          box_w_o          <= e_x2 - e_x1;
          box_h_o          <= e_y2 - e_y1;
          confidence_o     <= sc_s;
          last_detection_o <= ((fp_q + KCW'(1)) == kc_q);
          fp_q             <= fp_q + KCW'(1);
        end else begin
          label_o          <= '0;
          left_o           <= '0;
          top_o            <= '0;
          box_w_o          <= '0;
          box_h_o          <= '0;
          confidence_o     <= '0;
          last_detection_o <= 1'b0;
        end
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_v_q;

endmodule

// File: tb/detection_decode_with_nms_tb.sv
`timescale 1ns / 100ps

module detection_decode_with_nms_tb;
  import ddnms_pkg::*;

  localparam int CAND_MAX  = 1024;
  localparam int MAX_KEPT  = 300;
  localparam int CLASS_MAX = 128;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct {
    ddnms_command_e cmd;
    logic [31:0]    value;
    logic           last;
  } word_t;

  typedef struct {
    logic        valid_res;
    logic [6:0]  label;
    logic [28:0] left;
    logic [28:0] top;
    logic [28:0] box_w;
    logic [28:0] box_h;
    logic [30:0] confidence;
    logic        last_det;
    logic        ovf;
  } detection_t;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid_i, in_stall_o;
  logic command_i;
  logic signed [31:0] element_value_i;
  logic last_of_frame_i;
  logic out_valid_o, out_stall_i;
  logic valid_res_o;
  logic [6:0] label_o;
  logic [COORD_W-1:0] left_o, top_o, box_w_o, box_h_o;
  logic [SCORE_W-1:0] confidence_o;
  logic last_detection_o, overflow_o;

  detection_decode_with_nms dut (.*);

  // Stimulus and expectation stores
  word_t      word_q[$];
  detection_t fetch_exp_q[$];
  int errors;
  int n_words;
  int cyc;
  bit idle_on;
  bit hold_req;
  bit hold_done;
  int hold_left;
  int in_gap, out_gap;

  // Shadow decoder state
  int unsigned cls_reg, width_reg, height_reg, thr_reg;
  int unsigned elem_idx;
  longint      box_ch[4];
  longint      best_sc;
  int unsigned best_cl;
  int unsigned cx1[CAND_MAX], cx2[CAND_MAX], cy1[CAND_MAX], cy2[CAND_MAX];
  int unsigned c_sc[CAND_MAX], c_cl[CAND_MAX];
  int unsigned n_cand;
  int unsigned rank_buf[CAND_MAX];
  int unsigned kept_buf[MAX_KEPT];
  int unsigned n_kept, fetch_ptr;
  bit ovf_seen, frame_done;

  function automatic longint half_down(longint v);
    return v >= 0 ? (v >>> 1) : -(((-v) + 1) >>> 1);
  endfunction

  function automatic int unsigned clamp_px(longint v, longint hi);
    if (v < 0) return 0;
    if (v > hi) return int'(hi);
    return int'(v);
  endfunction

  function automatic bit boxes_overlap(int unsigned a, int unsigned b);
    longint unsigned lx, rx, ty, by, iw, ih, inter, aa, ab, uni;
    lx = cx1[a] > cx1[b] ? cx1[a] : cx1[b];
    rx = cx2[a] < cx2[b] ? cx2[a] : cx2[b];
    ty = cy1[a] > cy1[b] ? cy1[a] : cy1[b];
    by = cy2[a] < cy2[b] ? cy2[a] : cy2[b];
    iw = rx > lx ? rx - lx : 0;
    ih = by > ty ? by - ty : 0;
    inter = iw * ih;
    aa = longint'(cx2[a] - cx1[a]) * longint'(cy2[a] - cy1[a]);
    ab = longint'(cx2[b] - cx1[b]) * longint'(cy2[b] - cy1[b]);
    uni = aa + ab - inter;
    return uni > 0 && 2 * inter > uni;
  endfunction

  // Score the finished anchor and store it if it survives
  function automatic void close_anchor();
    longint hw, hh, wl, hl;
    int unsigned x1, x2, y1, y2;
    wl = longint'(width_reg) << 16;
    hl = longint'(height_reg) << 16;
    if (best_sc < longint'(thr_reg)) return;
    hw = half_down(box_ch[2]);
    hh = half_down(box_ch[3]);
    x1 = clamp_px(box_ch[0] - hw, wl);
    x2 = clamp_px(box_ch[0] + hw, wl);
    y1 = clamp_px(box_ch[1] - hh, hl);
    y2 = clamp_px(box_ch[1] + hh, hl);
    if (x2 <= x1 || y2 <= y1) return;
    if (n_cand >= CAND_MAX) begin
      ovf_seen = 1;
      return;
    end
    cx1[n_cand] = x1; cx2[n_cand] = x2;
    cy1[n_cand] = y1; cy2[n_cand] = y2;
    c_sc[n_cand] = int'(best_sc);
    c_cl[n_cand] = best_cl;
    n_cand++;
  endfunction

  // Rank by score, then suppress same-class overlaps greedily
  function automatic void run_nms();
    int unsigned j, c;
    bit drop;
    for (int unsigned i = 0; i < n_cand; i++) begin
      j = i;
      while (j > 0 && c_sc[rank_buf[j-1]] < c_sc[i]) begin
        rank_buf[j] = rank_buf[j-1];
        j--;
      end
      rank_buf[j] = i;
    end
    n_kept = 0;
    for (int unsigned i = 0; i < n_cand && n_kept < MAX_KEPT; i++) begin
      c = rank_buf[i];
      drop = 0;
      for (int unsigned k = 0; k < n_kept && !drop; k++)
        if (c_cl[kept_buf[k]] == c_cl[c] && boxes_overlap(c, kept_buf[k])) drop = 1;
      if (!drop) begin
        kept_buf[n_kept] = c;
        n_kept++;
      end
    end
    fetch_ptr = 0;
    elem_idx = 0;
    frame_done = 1;
  endfunction

  function automatic void decode_word(word_t w);
    longint v;
    int unsigned nc;
    detection_t d;
    int unsigned c;
    if (w.cmd == CMD_ELEMENT) begin
      v = longint'(signed'(w.value));
      nc = cls_reg < 1 ? 1 : (cls_reg > CLASS_MAX ? CLASS_MAX : cls_reg);
      if (frame_done) begin
        frame_done = 0;
        n_cand = 0;
        n_kept = 0;
        fetch_ptr = 0;
        ovf_seen = 0;
        elem_idx = 0;
      end
      if (elem_idx >= nc + 4) elem_idx = 0;
      if (elem_idx < 4) begin
        box_ch[elem_idx] = v;
        if (elem_idx == 0) begin
          best_sc = 0;
          best_cl = 0;
        end
      end else if (v > best_sc) begin
        best_sc = v;
        best_cl = elem_idx - 4;
      end
      elem_idx++;
      if (elem_idx >= nc + 4) begin
        close_anchor();
        elem_idx = 0;
      end
      if (w.last) run_nms();
      return;
    end
    d = '{default: '0};
    if (fetch_ptr < n_kept) begin
      c = kept_buf[fetch_ptr];
      d.valid_res  = 1;
      d.label      = c_cl[c][6:0];
      d.left       = cx1[c][28:0];
      d.top        = cy1[c][28:0];
      d.box_w      = 29'(cx2[c] - cx1[c]);
      d.box_h      = 29'(cy2[c] - cy1[c]);
      d.confidence = c_sc[c][30:0];
      d.last_det   = (fetch_ptr + 1 == n_kept);
      fetch_ptr++;
    end
    d.ovf = ovf_seen;
    fetch_exp_q.insert(fetch_exp_q.size(), d);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cyc, what, got, want);
    errors++;
  endtask

  // Clock and cycle limit
  initial clk_i = 0;
  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Input driver: hold a stalled word, otherwise advance or idle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_stall_o) begin
        // hold
      end else begin
        if (in_valid_i) begin
          decode_word(word_q[0]);
          word_q.pop_front();
        end
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
          in_gap <= $urandom_range(0, 9);
          in_valid_i <= 0;
        end else if (word_q.size() > 0) begin
          in_valid_i      <= 1;
          command_i       <= word_q[0].cmd;
          element_value_i <= word_q[0].value;
          last_of_frame_i <= word_q[0].last;
        end else begin
          in_valid_i <= 0;
        end
      end
    end
  end

  // Long receiver hold, counted on its own
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end else if (hold_req && !hold_done) begin
        hold_left <= 300;
        hold_done <= 1;
      end
    end
  end

  // Output monitor: check each accepted word, then choose next stall
  always @(posedge clk_i) begin
    detection_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (fetch_exp_q.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          e = fetch_exp_q.pop_front();
          if (valid_res_o !== e.valid_res) report_mismatch("valid_res", valid_res_o, e.valid_res);
          if (label_o !== e.label) report_mismatch("label", label_o, e.label);
          if (left_o !== e.left) report_mismatch("left", left_o, e.left);
          if (top_o !== e.top) report_mismatch("top", top_o, e.top);
          if (box_w_o !== e.box_w) report_mismatch("box_w", box_w_o, e.box_w);
          if (box_h_o !== e.box_h) report_mismatch("box_h", box_h_o, e.box_h);
          if (confidence_o !== e.confidence)
            report_mismatch("confidence", confidence_o, e.confidence);
          if (last_detection_o !== e.last_det)
            report_mismatch("last_detection", last_detection_o, e.last_det);
          if (overflow_o !== e.ovf) report_mismatch("overflow", overflow_o, e.ovf);
        end
      end
      if (hold_left > 0) begin
        out_stall_i <= 1;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall_i <= 1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_gap <= $urandom_range(0, 9);
        out_stall_i <= 1;
      end else begin
        out_stall_i <= 0;
      end
    end
  end

  task automatic push_elem(logic [31:0] v, logic last);
    word_t w;
    w = '{CMD_ELEMENT, v, last};
    word_q.insert(word_q.size(), w);
    n_words++;
  endtask

  task automatic push_fetch();
    word_t w;
    w = '{CMD_FETCH, $urandom, 1'($urandom_range(0, 1))};
    word_q.insert(word_q.size(), w);
    n_words++;
  endtask

  // Register write: setup cycle, then access cycle
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0;
    case (idx)
      REG_CLASS_COUNT: cls_reg = val[7:0];
      REG_NET_WIDTH:   width_reg = val[12:0];
      REG_NET_HEIGHT:  height_reg = val[12:0];
      default:         thr_reg = val[30:0];
    endcase
  endtask

  task automatic set_config(int unsigned c, int unsigned w, int unsigned h, int unsigned t);
    write_reg(REG_CLASS_COUNT, c);
    write_reg(REG_NET_WIDTH, w);
    write_reg(REG_NET_HEIGHT, h);
    write_reg(REG_SCORE_THR, t);
  endtask

  task automatic drain();
    while (word_q.size() != 0 || fetch_exp_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // One anchor, boxes grouped around a few centers so they overlap
  task automatic push_anchor(int unsigned nc, int unsigned ctr_x, int unsigned ctr_y, bit last);
    logic [31:0] v;
    push_elem(ctr_x + $urandom_range(0, 8 << 16) - (4 << 16), 0);
    push_elem(ctr_y + $urandom_range(0, 8 << 16) - (4 << 16), 0);
    push_elem($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(1 << 16, 40 << 16), 0);
    push_elem($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(1 << 16, 40 << 16), 0);
    for (int unsigned i = 0; i < nc; i++) begin
      case ($urandom_range(0, 5))
        0:       v = $urandom;
        1:       v = $urandom_range(0, 3) << 14;
        default: v = $urandom_range(0, 2 << 16);
      endcase
      push_elem(v, last && i == nc - 1);
    end
  endtask

  initial begin
    int unsigned nc, w, h, nf, cxs[3], cys[3];
    rst_ni = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid_i = 0; command_i = 0; element_value_i = 0; last_of_frame_i = 0;
    out_stall_i = 0;
    errors = 0; n_words = 0; cyc = 0; idle_on = 1; hold_req = 0; hold_done = 0;
    hold_left = 0; in_gap = 0; out_gap = 0;
    cls_reg = 80; width_reg = 640; height_reg = 640; thr_reg = 16384;
    elem_idx = 0; box_ch = '{default: 0}; best_sc = 0; best_cl = 0;
    n_cand = 0; n_kept = 0; fetch_ptr = 0; ovf_seen = 0; frame_done = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;

    // Directed: smallest sizes, zero threshold, zero class count acting as one
    push_fetch();
    drain();
    set_config(0, 1, 1, 0);
    // no positive score, huge box clamped to the frame
    push_elem(32'h0000_8000, 0); push_elem(32'h0000_8000, 0);
    push_elem(32'h7fff_ffff, 0); push_elem(32'h7fff_ffff, 0); push_elem(32'h8000_0000, 0);
    // negative center lands left of zero: empty box
    push_elem(32'h8000_0000, 0); push_elem(32'h0, 0);
    push_elem(32'h0002_0000, 0); push_elem(32'h0002_0000, 0); push_elem(32'h7fff_ffff, 0);
    // same center and width, negative height, higher score: empty box, dropped
    push_elem(32'h0000_8000, 0); push_elem(32'h0000_8000, 0);
    push_elem(32'h7fff_ffff, 0); push_elem(32'hffff_ffff, 0); push_elem(32'h0000_0005, 0);
    // partial anchor dropped at frame end
    push_elem(32'hffff_ffff, 0); push_elem(32'h0000_0001, 1);
    repeat (4) push_fetch();
    drain();

    // Largest sizes, class count above the limit, threshold at its top
    set_config(255, 4096, 4096, 32'h7fff_ffff);
    push_elem(32'h0800_0000, 0); push_elem(32'h0800_0000, 0);
    push_elem(32'h1000_0000, 0); push_elem(32'h0001_0000, 0);
    for (int i = 0; i < CLASS_MAX; i++)
      push_elem(i == CLASS_MAX - 1 ? 32'h7fff_ffff : $urandom_range(0, 1 << 20), i == CLASS_MAX - 1);
    repeat (2) push_fetch();
    drain();

    // Random frames
    while (n_words < 450) begin
      nc = $urandom_range(0, 9) == 0 ? $urandom_range(5, 128) : $urandom_range(1, 4);
      w = $urandom_range(0, 3) == 0 ? 4096 : $urandom_range(1, 300);
      h = $urandom_range(0, 3) == 0 ? 4096 : $urandom_range(1, 300);
      idle_on = (n_words < 370) && ($urandom_range(0, 3) != 0);
      set_config(nc, w, h, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 1 << 16));
      for (int i = 0; i < 3; i++) begin
        cxs[i] = $urandom_range(0, w << 16);
        cys[i] = $urandom_range(0, h << 16);
      end
      nf = nc > 8 ? $urandom_range(1, 2) : $urandom_range(2, 14);
      for (int unsigned a = 0; a < nf; a++) begin
        if ($urandom_range(0, 15) == 0) push_fetch();
        push_anchor(nc, cxs[a % 3], cys[a % 3], a == nf - 1);
      end
      if ($urandom_range(0, 5) == 0) begin
        push_elem($urandom, 0);
        push_elem($urandom, 1);
      end
      if (!hold_req && n_words > 200) begin
        hold_req = 1;
        repeat (40) push_fetch();
      end else begin
        repeat ($urandom_range(1, 10)) push_fetch();
      end
      drain();
    end

    drain();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
